### design/sacc_pkg.sv
`default_nettype none
package sacc_pkg;

  localparam int unsigned ANGLE_DIGITS = 3;

  localparam logic [1:0] ANGLE_DIGITS_C = 2'(ANGLE_DIGITS);
  localparam logic [9:0] ANGLE_SCALE = (ANGLE_DIGITS == 1) ? 10'd100 :
                                       (ANGLE_DIGITS == 2) ? 10'd10 : 10'd1;

  localparam logic [9:0]  MAX_ANGLE_RST = 10'd360;
  // floor(x/9) = (x * RECIP9) >> RECIP9_SH for x < 2^15
  localparam logic [13:0] RECIP9        = 14'd14564;
  localparam int unsigned RECIP9_SH     = 17;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;

  localparam logic [5:0] LED_PERIOD_FULL = 6'd25;
  localparam logic [5:0] LED_PERIOD_HALF = 6'd50;
  localparam logic [2:0] PHASE_CCW_FULL  = 3'd3;
  localparam logic [2:0] PHASE_CCW_HALF  = 3'd7;
  localparam logic [3:0] CW_IDX_MAX      = 4'd15;
  localparam logic [4:0] CCW_IDX_RST     = 5'd7;
  localparam logic [4:0] CCW_IDX_MIN     = 5'd16;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_WAIT   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FIELD_ANGLE = 2'd0,
    FIELD_DIR   = 2'd1,
    FIELD_SPEED = 2'd2
  } field_e;

  typedef struct packed {
    logic       cw;
    logic       full;
    logic [8:0] target;
  } cmd_t;

  typedef struct packed {
    logic       start;
    logic       invalid;
    logic       echo_valid;
    logic [3:0] echo_digit;
    field_e     field;
  } parse_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       driven;
    logic [7:0] leds;
    logic [8:0] steps;
    logic       report;
    logic       done;
  } rot_t;

  function automatic logic [3:0] full_coil(input logic [1:0] ph);
    logic [3:0] c;
    unique case (ph)
      2'd0: c = 4'h8;
      2'd1: c = 4'h1;
      2'd2: c = 4'h4;
      default: c = 4'h2;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] half_coil(input logic [2:0] ph);
    logic [3:0] c;
    unique case (ph)
      3'd0: c = 4'h8;
      3'd1: c = 4'h9;
      3'd2: c = 4'h1;
      3'd3: c = 4'h5;
      3'd4: c = 4'h4;
      3'd5: c = 4'h8;
      3'd6: c = 4'h2;
      default: c = 4'h8;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bar_of(input logic [4:0] idx);
    logic [7:0] b;
    b = '0;
    if (idx[4:3] == 2'b00) begin
      b[idx[2:0]] = 1'b1;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### design/sacc_parser.sv
`default_nettype none
module sacc_parser
  import sacc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] rx_char_i,
  input  wire logic       clear_i,
  input  wire logic [9:0] max_angle_i,
  output parse_t          parse_o,
  output cmd_t            cmd_o
);

  field_e      field_q, field_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  angle_q, angle_d;
  logic [10:0] q9_q;
  logic        dir_given_q, dir_given_d;
  logic [3:0]  dir_q, dir_d;
  logic        spd_given_q, spd_given_d;
  logic [3:0]  spd_q, spd_d;

  logic        is_digit, is_comma;
  logic [7:0]  ch_off;
  logic [3:0]  dval;
  logic [13:0] ang_mul10, angle_acc;
  logic [27:0] prod;
  logic [10:0] q9_sel;
  logic        cmd_ok;
  parse_t      p;

  assign is_digit  = (rx_char_i >= CH_ZERO) && (rx_char_i <= CH_NINE);
  assign is_comma  = (rx_char_i == CH_COMMA);
  assign ch_off    = rx_char_i - CH_ZERO;
  assign dval      = ch_off[3:0];

  assign ang_mul10 = {1'b0, angle_q, 3'b000} + {3'b000, angle_q, 1'b0};
  assign angle_acc = ang_mul10 + {10'd0, dval};
  assign prod      = {14'd0, ang_mul10} * {14'd0, RECIP9};

  assign q9_sel = spd_q[0] ? {1'b0, q9_q[10:1]} : q9_q;
  assign cmd_o.cw     = dir_q[0];
  assign cmd_o.full   = spd_q[0];
  assign cmd_o.target = (q9_sel[10:9] != 2'b00) ? 9'h1FF : q9_sel[8:0];

  assign cmd_ok = (angle_q <= max_angle_i) && dir_given_q && (dir_q <= 4'd1) &&
                  (spd_q <= 4'd1);

  always_comb begin
    field_d     = field_q;
    cnt_d       = cnt_q;
    angle_d     = angle_q;
    dir_given_d = dir_given_q;
    dir_d       = dir_q;
    spd_given_d = spd_given_q;
    spd_d       = spd_q;
    p           = '0;
    p.field     = field_q;
    if (en_i) begin
      unique case (field_q)
        FIELD_ANGLE: begin
          if (cnt_q < ANGLE_DIGITS_C) begin
            if (is_digit) begin
              angle_d      = angle_acc[9:0];
              cnt_d        = cnt_q + 2'd1;
              p.echo_valid = 1'b1;
              p.echo_digit = dval;
            end
          end else if (is_comma) begin
            angle_d = angle_q * ANGLE_SCALE;
            field_d = FIELD_DIR;
            cnt_d   = '0;
          end
        end
        FIELD_DIR: begin
          if (!dir_given_q) begin
            if (is_digit) begin
              dir_given_d  = 1'b1;
              dir_d        = dval;
              p.echo_valid = 1'b1;
              p.echo_digit = dval;
            end
          end else if (is_comma) begin
            field_d = FIELD_SPEED;
            cnt_d   = '0;
          end
        end
        FIELD_SPEED: begin
          if (!spd_given_q) begin
            if (is_digit) begin
              spd_given_d  = 1'b1;
              spd_d        = dval;
              p.echo_valid = 1'b1;
              p.echo_digit = dval;
            end
          end else if (is_comma) begin
            if (cmd_ok) begin
              p.start = 1'b1;
              field_d = FIELD_ANGLE;
              cnt_d   = '0;
            end else begin
              p.invalid = 1'b1;
            end
          end
        end
        default: begin
          field_d = FIELD_ANGLE;
        end
      endcase
    end
    if (clear_i || p.invalid) begin
      field_d     = FIELD_ANGLE;
      cnt_d       = '0;
      angle_d     = '0;
      dir_given_d = 1'b0;
      dir_d       = '0;
      spd_given_d = 1'b0;
      spd_d       = '0;
    end
    p.field = field_d;
  end

  assign parse_o = p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= FIELD_ANGLE;
      cnt_q       <= '0;
      angle_q     <= '0;
      dir_given_q <= 1'b0;
      dir_q       <= '0;
      spd_given_q <= 1'b0;
      spd_q       <= '0;
    end else begin
      field_q     <= field_d;
      cnt_q       <= cnt_d;
      angle_q     <= angle_d;
      dir_given_q <= dir_given_d;
      dir_q       <= dir_d;
      spd_given_q <= spd_given_d;
      spd_q       <= spd_d;
    end
  end

  // quotient is registered from the angle in the cycle after it, long before the speed field closes
  always_ff @(posedge clk_i) begin
    q9_q <= prod[RECIP9_SH +: 11];
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ANGLE_DIGITS_C)
    else $error("digit count beyond angle width");

  a_cnt_only_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q != FIELD_ANGLE |-> cnt_q == 2'd0)
    else $error("digit count left set outside angle field");

endmodule
`default_nettype wire

### design/sacc_rotor.sv
`default_nettype none
module sacc_rotor
  import sacc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic clear_i,
  input  wire logic start_i,
  input  wire logic tick_i,
  input  wire cmd_t cmd_i,
  output rot_t      rot_o
);

  logic [8:0] target_q, target_d;
  logic [8:0] count_q, count_d;
  logic [2:0] phase_q, phase_d;
  logic [3:0] cw_idx_q, cw_idx_d;
  logic [4:0] ccw_idx_q, ccw_idx_d;
  logic [5:0] led_cnt_q, led_cnt_d;
  logic [3:0] coil_q, coil_d;
  logic [7:0] led_q, led_d;

  logic       done, driven, report, led_hit;
  logic [2:0] ph_inc, ph_last;
  logic [5:0] led_cnt_inc, led_period;

  assign done        = count_q >= target_q;
  assign ph_inc      = phase_q + 3'd1;
  assign ph_last     = cmd_i.full ? PHASE_CCW_FULL : PHASE_CCW_HALF;
  assign led_period  = cmd_i.full ? LED_PERIOD_FULL : LED_PERIOD_HALF;
  assign led_cnt_inc = led_cnt_q + 6'd1;
  assign led_hit     = (led_cnt_inc == led_period);

  always_comb begin
    target_d  = target_q;
    count_d   = count_q;
    phase_d   = phase_q;
    cw_idx_d  = cw_idx_q;
    ccw_idx_d = ccw_idx_q;
    led_cnt_d = led_cnt_q;
    coil_d    = coil_q;
    led_d     = led_q;
    driven    = 1'b0;
    report    = 1'b0;
    if (clear_i) begin
      target_d  = '0;
      count_d   = '0;
      phase_d   = '0;
      cw_idx_d  = '0;
      ccw_idx_d = CCW_IDX_RST;
      led_cnt_d = '0;
    end else if (start_i) begin
      target_d = cmd_i.target;
      phase_d  = cmd_i.cw ? 3'd0 : ph_last;
    end else if (tick_i) begin
      if (!done) begin
        coil_d  = cmd_i.full ? full_coil(phase_q[1:0]) : half_coil(phase_q);
        driven  = 1'b1;
        if (cmd_i.cw) begin
          phase_d = (cmd_i.full && ph_inc == 3'd4) ? 3'd0 : ph_inc;
        end else begin
          phase_d = (phase_q == 3'd0) ? ph_last : phase_q - 3'd1;
        end
        count_d = count_q + 9'd1;
        report  = cmd_i.full ? (count_d[2:0] == 3'd0) : (count_d[3:0] == 4'd0);
        led_cnt_d = led_hit ? 6'd0 : led_cnt_inc;
        if (led_hit) begin
          if (cmd_i.cw) begin
            led_d = bar_of({1'b0, cw_idx_q});
            if (cw_idx_q != CW_IDX_MAX) begin
              cw_idx_d = cw_idx_q + 4'd1;
            end
          end else begin
            led_d = bar_of(ccw_idx_q);
            if (ccw_idx_q != CCW_IDX_MIN) begin
              ccw_idx_d = ccw_idx_q - 5'd1;
            end
          end
        end
      end else begin
        led_d = '0;
      end
    end
  end

  assign rot_o.coils  = coil_d;
  assign rot_o.driven = driven;
  assign rot_o.leds   = led_d;
  assign rot_o.steps  = count_d;
  assign rot_o.report = report;
  assign rot_o.done   = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      count_q   <= '0;
      phase_q   <= '0;
      cw_idx_q  <= '0;
      ccw_idx_q <= CCW_IDX_RST;
      led_cnt_q <= '0;
      coil_q    <= '0;
      led_q     <= '0;
    end else begin
      target_q  <= target_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      cw_idx_q  <= cw_idx_d;
      ccw_idx_q <= ccw_idx_d;
      led_cnt_q <= led_cnt_d;
      coil_q    <= coil_d;
      led_q     <= led_d;
    end
  end

  a_count_le_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= target_q)
    else $error("step count passed target");

  a_full_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && !done && cmd_i.full |=> phase_q[2] == 1'b0)
    else $error("full-step phase out of table");

endmodule
`default_nettype wire

### design/stepper_angle_command_controller.sv
// Stepper angle command controller.
// Input stream: s_axis_tuser carries the kind (0 character, 1 step tick,
// 2 abort), s_axis_tdata the received character. Each request yields one
// result on the m_axis side carrying coil drive, LED bar, echoed digit,
// mode, field being read, step count and report/finish flags.
// Commands arrive as angle digits, direction digit, speed digit, each
// closed by a comma; a valid command starts a rotation, an invalid one
// clears back to the reading state. '*' after the end or an abort clears.
// Timing: a request is registered on entry, then processed into the result
// register; m_axis_tvalid rises when the result register is loaded, and one
// request is taken per cycle in steady state while the receiver keeps up.
// If the receiver stalls, the result register holds and the input register
// fills; s_axis_tready drops only when both are occupied.
// cfg_we_i/cfg_wdata_i write the maximum angle; write only when idle.
// Reset: reading mode, angle field, max angle 360, coils and LEDs off,
// both stages empty.
`default_nettype none
module stepper_angle_command_controller
  import sacc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_char
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] coils, [4] coils_driven, [12:5] leds, [16:13] echo_digit,
  // [17] echo_valid, [19:18] mode, [21:20] read_field, [30:22] steps_done,
  // [31] report_point, [32] finished, [39:33] zero
  output logic [39:0]      m_axis_tdata
);

  logic [9:0]  max_angle_q;
  logic        in_v_q;
  logic [1:0]  in_act_q;
  logic [7:0]  in_ch_q;
  logic        out_v_q;
  logic [39:0] out_data_q, out_data_d;
  mode_e       mode_q, mode_d;

  logic   adv, fire, char_ev, tick_ev, abort_ev, star_clr, fin;
  parse_t parse;
  cmd_t   cmd;
  rot_t   rot;

  assign adv           = !out_v_q || m_axis_tready;
  assign fire          = in_v_q && adv;
  assign s_axis_tready = !in_v_q || adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  assign char_ev  = fire && (in_act_q == ACT_CHAR);
  assign tick_ev  = fire && (in_act_q == ACT_TICK);
  assign abort_ev = fire && (in_act_q == ACT_ABORT);
  assign star_clr = char_ev && (mode_q == MODE_WAIT) && (in_ch_q == CH_STAR);

  sacc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (char_ev && (mode_q == MODE_READ)),
    .rx_char_i   (in_ch_q),
    .clear_i     (star_clr),
    .max_angle_i (max_angle_q),
    .parse_o     (parse),
    .cmd_o       (cmd)
  );

  sacc_rotor u_rotor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (star_clr || parse.invalid),
    .start_i (parse.start),
    .tick_i  (tick_ev && (mode_q == MODE_ROTATE)),
    .cmd_i   (cmd),
    .rot_o   (rot)
  );

  always_comb begin
    mode_d = mode_q;
    fin    = 1'b0;
    unique case (mode_q)
      MODE_READ: begin
        if (parse.start) begin
          mode_d = MODE_ROTATE;
        end
      end
      MODE_ROTATE: begin
        if ((tick_ev && rot.done) || abort_ev) begin
          mode_d = MODE_WAIT;
          fin    = 1'b1;
        end
      end
      MODE_WAIT: begin
        if (star_clr) begin
          mode_d = MODE_READ;
        end
      end
      default: begin
        mode_d = MODE_READ;
      end
    endcase
  end

  assign out_data_d = {7'd0, fin, rot.report, rot.steps, parse.field, mode_d,
                       parse.echo_valid, parse.echo_digit, rot.leds, rot.driven,
                       rot.coils};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_angle_q <= MAX_ANGLE_RST;
      in_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      mode_q      <= MODE_READ;
    end else begin
      if (cfg_we_i) begin
        max_angle_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q <= s_axis_tuser;
      in_ch_q  <= s_axis_tdata;
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  a_fin_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && fin |=> mode_q == MODE_WAIT && out_data_q[32])
    else $error("finish without entering wait");

  a_start_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse.start |-> mode_q == MODE_READ && char_ev)
    else $error("command start outside reading");

endmodule
`default_nettype wire

### dv/stepper_angle_command_controller_tb.sv
module stepper_angle_command_controller_tb
  import sacc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_NONE   = 2'd3;
  localparam logic [7:0]  CODE_UNSET = 8'hFF;
  // coil tables, entry 0 in the lowest nibble
  localparam logic [15:0] FULL_TAB   = {4'h2, 4'h4, 4'h1, 4'h8};
  localparam logic [31:0] HALF_TAB   = {4'h8, 4'h2, 4'h8, 4'h4, 4'h5, 4'h1, 4'h9, 4'h8};

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] ch;
  } request_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       finished;
    logic       report;
    logic [8:0] steps;
    field_e     field;
    mode_e      mode;
    logic       echo_v;
    logic [3:0] echo_d;
    logic [7:0] leds;
    logic       driven;
    logic [3:0] coils;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  stepper_angle_command_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // controller state as predicted
  logic [9:0] max_q;
  mode_e      mode_q;
  field_e     field_q;
  logic [1:0] digit_cnt;
  logic [3:0] ang_dig [3];
  logic [7:0] dir_code, spd_code;
  logic [8:0] step_tgt, step_cnt;
  logic [2:0] phase_q;
  logic [3:0] cw_idx;
  logic [4:0] ccw_idx;
  logic [3:0] coil_hold;
  logic [7:0] led_hold;

  request_t req_queue[$];
  result_t  due_results[$];
  int       queued_count = 0;
  int       accepted_count = 0;
  int       mismatches = 0;
  bit       in_fire = 1'b0;
  bit       out_fire = 1'b0;
  bit       tx_quiet = 1'b0;
  bit       rx_quiet = 1'b0;
  bit       hold_on = 1'b0;
  int       tx_gap = 0;
  int       rx_stall = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic clear_command();
    mode_q    = MODE_READ;
    field_q   = FIELD_ANGLE;
    digit_cnt = '0;
    ang_dig   = '{4'd0, 4'd0, 4'd0};
    dir_code  = CODE_UNSET;
    spd_code  = CODE_UNSET;
    step_tgt  = '0;
    step_cnt  = '0;
    phase_q   = '0;
    cw_idx    = '0;
    ccw_idx   = CCW_IDX_RST;
  endtask

  function automatic logic [7:0] led_bar(input int idx);
    return (idx >= 0 && idx < 8) ? 8'(1 << idx) : 8'h00;
  endfunction

  task automatic advance_controller(input logic [1:0] act, input logic [7:0] ch,
                                    output result_t r);
    bit         is_dig;
    bit         full_mode;
    logic [3:0] dval;
    int         angle, tgt, len, nph;
    r      = '0;
    is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval   = is_dig ? 4'(ch - CH_ZERO) : 4'd0;
    if (mode_q == MODE_READ && act == ACT_CHAR) begin
      case (field_q)
        FIELD_ANGLE: begin
          if (digit_cnt < ANGLE_DIGITS) begin
            if (is_dig) begin
              ang_dig[digit_cnt] = dval;
              digit_cnt = digit_cnt + 2'd1;
              r.echo_d = dval;
              r.echo_v = 1'b1;
            end
          end else if (ch == CH_COMMA) begin
            field_q   = FIELD_DIR;
            digit_cnt = '0;
          end
        end
        FIELD_DIR: begin
          if (dir_code == CODE_UNSET) begin
            if (is_dig) begin
              dir_code = 8'(dval);
              r.echo_d = dval;
              r.echo_v = 1'b1;
            end
          end else if (ch == CH_COMMA) begin
            field_q   = FIELD_SPEED;
            digit_cnt = '0;
          end
        end
        FIELD_SPEED: begin
          if (spd_code == CODE_UNSET) begin
            if (is_dig) begin
              spd_code = 8'(dval);
              r.echo_d = dval;
              r.echo_v = 1'b1;
            end
          end else if (ch == CH_COMMA) begin
            angle = ang_dig[0] * 100 + ang_dig[1] * 10 + ang_dig[2];
            if (angle > max_q || dir_code > 8'd1 || spd_code > 8'd1) begin
              clear_command();
            end else begin
              tgt = (angle * 10) / (9 * (spd_code + 1));
              if (tgt > 511) tgt = 511;
              step_tgt  = 9'(tgt);
              mode_q    = MODE_ROTATE;
              field_q   = FIELD_ANGLE;
              digit_cnt = '0;
              if (dir_code == 8'd0) begin
                phase_q = (spd_code == 8'd1) ? PHASE_CCW_FULL : PHASE_CCW_HALF;
              end else begin
                phase_q = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (mode_q == MODE_ROTATE && act == ACT_TICK) begin
      if (step_cnt < step_tgt) begin
        full_mode = (spd_code == 8'd1);
        len       = full_mode ? 4 : 8;
        coil_hold = full_mode ? FULL_TAB[{phase_q[1:0], 2'b00} +: 4]
                              : HALF_TAB[{phase_q, 2'b00} +: 4];
        r.driven  = 1'b1;
        if (dir_code == 8'd1) begin
          nph = (phase_q + 1) % 8;
          if (nph == len) nph = 0;
        end else begin
          nph = (phase_q == 3'd0) ? len - 1 : phase_q - 1;
        end
        phase_q  = 3'(nph);
        step_cnt = step_cnt + 9'd1;
        if (step_cnt % (full_mode ? 8 : 16) == 0) r.report = 1'b1;
        if (step_cnt % (full_mode ? 25 : 50) == 0) begin
          if (dir_code == 8'd1) begin
            led_hold = led_bar(cw_idx);
            if (cw_idx < CW_IDX_MAX) cw_idx = cw_idx + 4'd1;
          end else begin
            led_hold = led_bar(ccw_idx);
            if (ccw_idx != CCW_IDX_MIN) ccw_idx = ccw_idx - 5'd1;
          end
        end
      end else begin
        led_hold   = '0;
        mode_q     = MODE_WAIT;
        r.finished = 1'b1;
      end
    end else if (mode_q == MODE_ROTATE && act == ACT_ABORT) begin
      mode_q     = MODE_WAIT;
      r.finished = 1'b1;
    end else if (mode_q == MODE_WAIT && act == ACT_CHAR && ch == CH_STAR) begin
      clear_command();
    end
    r.coils = coil_hold;
    r.leds  = led_hold;
    r.mode  = mode_q;
    r.field = field_q;
    r.steps = step_cnt;
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // request and result monitor, prediction on every accepted request
  always @(posedge clk_i) begin : monitor
    result_t exp_r, got_r, pred_r;
    if (rst_ni) begin
      in_fire  = s_axis_tvalid && s_axis_tready;
      out_fire = m_axis_tvalid && m_axis_tready;
      if (out_fire) begin
        got_r = result_t'(m_axis_tdata);
        if (due_results.size() == 0) begin
          $error("result %h with no request outstanding", m_axis_tdata);
          mismatches++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("coils", exp_r.coils, got_r.coils);
          check_field("coils_driven", exp_r.driven, got_r.driven);
          check_field("leds", exp_r.leds, got_r.leds);
          check_field("echo_digit", exp_r.echo_d, got_r.echo_d);
          check_field("echo_valid", exp_r.echo_v, got_r.echo_v);
          check_field("mode", exp_r.mode, got_r.mode);
          check_field("read_field", exp_r.field, got_r.field);
          check_field("steps_done", exp_r.steps, got_r.steps);
          check_field("report_point", exp_r.report, got_r.report);
          check_field("finished", exp_r.finished, got_r.finished);
          check_field("padding", exp_r.pad, got_r.pad);
        end
      end
      if (in_fire) begin
        advance_controller(s_axis_tuser, s_axis_tdata, pred_r);
        due_results.push_back(pred_r);
        accepted_count++;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    request_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          req = req_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req.act;
          s_axis_tdata  <= req.ch;
          if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 16);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
        rx_stall = rx_quiet ? 0 : $urandom_range(0, 16);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      m_axis_tready <= (rx_stall == 0) && !hold_on;
    end
  end

  // long receiver back-pressure so both stages fill and tready drops
  initial begin : long_hold
    while (!(accepted_count >= 150 && req_queue.size() > 8)) @(posedge clk_i);
    hold_on = 1'b1;
    repeat (120) @(posedge clk_i);
    hold_on = 1'b0;
  end

  task automatic push_req(input logic [1:0] act, input logic [7:0] ch);
    req_queue.push_back('{act: act, ch: ch});
    queued_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_req(ACT_CHAR, 8'(s[i]));
  endtask

  function automatic logic [7:0] rand_nondigit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  task automatic push_cmd(input int angle, input int dir_d, input int spd_d, input bit noisy);
    int digs[5];
    digs = '{angle / 100, (angle / 10) % 10, angle % 10, dir_d, spd_d};
    for (int i = 0; i < 5; i++) begin
      if (noisy && $urandom_range(0, 2) == 0) push_req(ACT_CHAR, rand_nondigit());
      push_req(ACT_CHAR, 8'(CH_ZERO + digs[i]));
      if (i >= 2) begin
        // surplus digit once the field is full is ignored
        if (noisy && $urandom_range(0, 3) == 0)
          push_req(ACT_CHAR, 8'(CH_ZERO + $urandom_range(0, 9)));
        push_req(ACT_CHAR, CH_COMMA);
      end
    end
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_req($urandom_range(0, 1) ? ACT_CHAR : ACT_NONE, 8'($urandom_range(0, 255)));
      push_req(ACT_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // long rotations are cut short by an abort
  task automatic push_rotation(input int tgt);
    if (tgt > 40 || $urandom_range(0, 6) == 0) begin
      push_ticks($urandom_range(0, (tgt > 40) ? 40 : tgt));
      push_req(ACT_ABORT, 8'($urandom_range(0, 255)));
    end else begin
      push_ticks(tgt + 1 + $urandom_range(0, 2));
    end
    if ($urandom_range(0, 2) == 0) push_req(ACT_CHAR, 8'($urandom_range(0, 41)));
    push_req(ACT_CHAR, CH_STAR);
  endtask

  task automatic run_random(input int budget);
    int start, kind, angle, dir_d, spd_d, cap;
    start = queued_count;
    while (queued_count - start < budget) begin
      kind = $urandom_range(0, 9);
      cap  = (max_q < 40) ? max_q : 40;
      if (kind < 7) begin
        angle = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_q) : $urandom_range(0, cap);
        dir_d = $urandom_range(0, 1);
        spd_d = $urandom_range(0, 1);
        push_cmd(angle, dir_d, spd_d, $urandom_range(0, 1));
        cap = (angle * 10) / (9 * (spd_d + 1));
        push_rotation(cap > 511 ? 511 : cap);
      end else if (kind == 7) begin
        kind  = $urandom_range(0, 2);
        angle = $urandom_range(0, cap);
        dir_d = $urandom_range(0, 1);
        spd_d = $urandom_range(0, 1);
        if (kind == 0 && max_q < 999) angle = $urandom_range(max_q + 1, 999);
        else if (kind == 2) spd_d = $urandom_range(2, 9);
        else dir_d = $urandom_range(2, 9);
        push_cmd(angle, dir_d, spd_d, $urandom_range(0, 1));
        push_req(ACT_TICK, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (!(accepted_count == queued_count && due_results.size() == 0)) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_angle(input logic [9:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    max_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int settings[5];
    max_q     = MAX_ANGLE_RST;
    coil_hold = '0;
    led_hold  = '0;
    clear_command();
    settings = '{MAX_ANGLE_RST, 0, 999, 24, $urandom_range(0, 999)};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (settings[p]) begin
      wait_idle();
      write_max_angle(10'(settings[p]));
      if (p == 0) begin
        // requests with no effect while reading
        push_req(ACT_NONE, 8'hFF);
        push_req(ACT_TICK, 8'h00);
        push_req(ACT_ABORT, "5");
        push_req(ACT_CHAR, CH_STAR);
        // angle one above the limit
        push_text("361,1,1,");
        // short ccw full-step run, char while rotating, abort, tick after abort
        push_text("009,0,1,");
        push_ticks(3);
        push_req(ACT_CHAR, "x");
        push_req(ACT_ABORT, 8'h00);
        push_req(ACT_TICK, 8'hFF);
        push_req(ACT_CHAR, CH_STAR);
      end
      if (settings[p] == 999) begin
        // target saturation, ccw full-step index run past the first LED
        push_text("999,0,1,");
        push_ticks(230);
        push_req(ACT_ABORT, 8'h00);
        push_req(ACT_CHAR, CH_STAR);
      end
      run_random(12);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
design/sacc_pkg.sv
design/sacc_parser.sv
design/sacc_rotor.sv
design/stepper_angle_command_controller.sv
dv/stepper_angle_command_controller_tb.sv
